// File: src/rightmost_substring_search_assert.svh
// Assertion macros used by the search block's back end.
`ifndef RIGHTMOST_SUBSTRING_SEARCH_ASSERT_SVH
`define RIGHTMOST_SUBSTRING_SEARCH_ASSERT_SVH

// cond must hold at every clock edge outside reset
`define RSS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold at every edge where ante holds
`define RSS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/rss_pkg.sv
// Types and constants of the rightmost substring search block.
package rss_pkg;

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // item class: {is_text, has_byte}
  typedef enum logic [1:0] {
    OP_PAT_MARK  = 2'b00,
    OP_PAT_BYTE  = 2'b01,
    OP_TEXT_MARK = 2'b10,
    OP_TEXT_BYTE = 2'b11
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              last;
    logic [BYTE_W-1:0] data;
  } q_item_t;

endpackage

// File: src/rss_in_if.sv
// Input channel: pattern and text items.
interface rss_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [rss_pkg::BYTE_W-1:0] data_byte;
  logic                      byte_valid;
  logic                      last;

  modport source (output valid, command, data_byte, byte_valid, last, input ready);
  modport sink   (input valid, command, data_byte, byte_valid, last, output ready);
endinterface

// File: src/rss_out_if.sv
// Result channel: match flag, position and overflow.
interface rss_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [rss_pkg::POS_W-1:0] position;
  logic                      overflow;

  modport source (output valid, found, position, overflow, input ready);
  modport sink   (input valid, found, position, overflow, output ready);
endinterface

// File: src/rss_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module rss_front (
  input  logic             clk,
  input  logic             rst,
  rss_in_if.sink           request,
  output rss_pkg::q_item_t head,
  output logic             head_valid,
  input  logic             pop
);

  rss_pkg::q_item_t            queue [rss_pkg::QUEUE_DEPTH];
  logic [rss_pkg::QPTR_W-1:0]  wptr;
  logic [rss_pkg::QPTR_W-1:0]  rptr;
  logic [rss_pkg::QCNT_W-1:0]  count;
  logic                        push;
  rss_pkg::q_item_t            incoming;

  function automatic logic [rss_pkg::QPTR_W-1:0] bump(input logic [rss_pkg::QPTR_W-1:0] p);
    if (p == rss_pkg::QPTR_W'(rss_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + rss_pkg::QPTR_W'(1);
  endfunction

  always_comb begin
    incoming.op   = rss_pkg::op_t'({request.command, request.byte_valid});
    incoming.last = request.last;
    incoming.data = request.data_byte;
  end

  assign request.ready = (count != rss_pkg::QCNT_W'(rss_pkg::QUEUE_DEPTH));
  assign push          = request.valid && request.ready;
  assign head_valid    = (count != '0);
  assign head          = queue[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= bump(wptr);
      end
      if (pop) begin
        rptr <= bump(rptr);
      end
      if (push && !pop) begin
        count <= count + rss_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - rss_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= incoming;
    end
  end

endmodule

// File: src/rss_back.sv
// Back end: pattern shift line, text window, parallel compare and result register.
`include "rightmost_substring_search_assert.svh"

module rss_back #(
  parameter int MAX_TEXT    = 128,
  parameter int MAX_PATTERN = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  rss_pkg::q_item_t head,
  input  logic             head_valid,
  output logic             pop,
  rss_out_if.source        result
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam int SW = (CW > rss_pkg::POS_W) ? CW : rss_pkg::POS_W;

  // pattern held newest byte first, so pat[j] lines up with win[j]
  logic [rss_pkg::BYTE_W-1:0] pat [MAX_PATTERN];
  logic [rss_pkg::BYTE_W-1:0] win [MAX_PATTERN];
  logic [rss_pkg::BYTE_W-1:0] win_new [MAX_PATTERN];

  logic [LW-1:0]            plen, plen_next, plen_base;
  logic                     popen, popen_next;
  logic [CW-1:0]            count, count_next;
  logic                     match_found, match_found_next;
  logic [rss_pkg::POS_W-1:0] match_start, match_start_next;
  logic                     overflow_seen, overflow_seen_next;

  logic                     rvalid, rvalid_next;
  logic                     rfound, rfound_next;
  logic [rss_pkg::POS_W-1:0] rpos, rpos_next;
  logic                     rovf, rovf_next;

  logic                     is_emit, pat_shift, win_shift, hit;
  logic [MAX_PATTERN-1:0]   eq;
  logic [SW-1:0]            diff;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      win_new[j] = (j == 0) ? head.data : win[(j == 0) ? 0 : j - 1];
      eq[j]      = (win_new[j] == pat[j]) || (j >= int'(plen));
    end
  end

  always_comb begin
    plen_next          = plen;
    popen_next         = popen;
    count_next         = count;
    match_found_next   = match_found;
    match_start_next   = match_start;
    overflow_seen_next = overflow_seen;
    rvalid_next        = rvalid && !result.ready;
    rfound_next        = rfound;
    rpos_next          = rpos;
    rovf_next          = rovf;
    pat_shift          = 1'b0;
    win_shift          = 1'b0;
    hit                = 1'b0;
    diff               = '0;
    plen_base          = popen ? plen : '0;

    is_emit = head.last && (head.op == rss_pkg::OP_TEXT_BYTE ||
                            head.op == rss_pkg::OP_TEXT_MARK);
    pop     = head_valid && (!is_emit || !rvalid || result.ready);

    if (pop) begin
      unique case (head.op)
        rss_pkg::OP_PAT_MARK, rss_pkg::OP_PAT_BYTE: begin
          if (!popen) begin
            plen_next          = '0;
            count_next         = '0;
            match_found_next   = 1'b0;
            match_start_next   = '0;
            overflow_seen_next = 1'b0;
          end
          if (head.op == rss_pkg::OP_PAT_BYTE) begin
            if (plen_base < LW'(MAX_PATTERN)) begin
              pat_shift = 1'b1;
              plen_next = plen_base + LW'(1);
            end else begin
              overflow_seen_next = 1'b1;
            end
          end
          popen_next = !head.last;
        end
        rss_pkg::OP_TEXT_MARK, rss_pkg::OP_TEXT_BYTE: begin
          popen_next = 1'b0;
          if (head.op == rss_pkg::OP_TEXT_BYTE) begin
            if (count < CW'(MAX_TEXT)) begin
              win_shift  = 1'b1;
              count_next = count + CW'(1);
              hit = (plen != '0) && (int'(count_next) >= int'(plen)) && (&eq);
              if (hit) begin
                diff             = SW'(count_next) - SW'(plen);
                match_found_next = 1'b1;
                match_start_next = diff[rss_pkg::POS_W-1:0];
              end
            end else begin
              overflow_seen_next = 1'b1;
            end
          end
          if (head.last) begin
            rvalid_next        = 1'b1;
            rfound_next        = match_found_next;
            rpos_next          = match_found_next ? match_start_next : '0;
            rovf_next          = overflow_seen_next;
            count_next         = '0;
            match_found_next   = 1'b0;
            match_start_next   = '0;
            overflow_seen_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen          <= '0;
      popen         <= 1'b0;
      count         <= '0;
      match_found   <= 1'b0;
      match_start   <= '0;
      overflow_seen <= 1'b0;
      rvalid        <= 1'b0;
    end else begin
      plen          <= plen_next;
      popen         <= popen_next;
      count         <= count_next;
      match_found   <= match_found_next;
      match_start   <= match_start_next;
      overflow_seen <= overflow_seen_next;
      rvalid        <= rvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    rfound <= rfound_next;
    rpos   <= rpos_next;
    rovf   <= rovf_next;
    if (pat_shift) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        pat[j] <= (j == 0) ? head.data : pat[(j == 0) ? 0 : j - 1];
      end
    end
    if (win_shift) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        win[j] <= win_new[j];
      end
    end
  end

  assign result.valid    = rvalid;
  assign result.found    = rfound;
  assign result.position = rpos;
  assign result.overflow = rovf;

  `RSS_ASSERT_ALWAYS(a_plen_bound, clk, rst, int'(plen) <= MAX_PATTERN, "pattern length past bound")
  `RSS_ASSERT_ALWAYS(a_count_bound, clk, rst, int'(count) <= MAX_TEXT, "text count past bound")
  `RSS_ASSERT_IMPLIES(a_match_sane, clk, rst, match_found,
                      plen != '0 && int'(count) >= int'(plen), "match with too short text")
  `RSS_ASSERT_IMPLIES(a_pos_zero, clk, rst, rvalid && !rfound, rpos == '0,
                      "position set without a match")

endmodule

// File: src/rightmost_substring_search.sv
// Top level of the rightmost substring search block.
//
//   channel   role    payload
//   request   sink    command, data_byte, byte_valid, last
//   result    source  found, position, overflow
//
// One item per cycle is sustained, text bytes included, while the result is not
// stalled, since the whole window is compared in parallel. A request passes
// through the two-entry queue and then the result register. Reset is synchronous;
// it clears lengths, counters, flags and the queue; pattern and window bytes are
// not cleared. A stalled result holds text items that end a string at the head
// of the queue, and the items queued behind them; other items keep flowing while
// the queue has room.
module rightmost_substring_search #(
  parameter int MAX_TEXT    = 128,
  parameter int MAX_PATTERN = 16
) (
  input logic        clk,
  input logic        rst,
  rss_in_if.sink     request,
  rss_out_if.source  result
);

  rss_pkg::q_item_t head;
  logic             head_valid;
  logic             pop;

  rss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  rss_back #(
    .MAX_TEXT    (MAX_TEXT),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

endmodule

// File: tb/rss_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the substring search block: predicts results from accepted items and checks them.
module rss_checker #(
  parameter int MAX_TEXT    = 128,
  parameter int MAX_PATTERN = 16
) (
  input  logic clk,
  input  logic rst,
  rss_in_if    request,
  rss_out_if   result,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic                      found;
    logic [rss_pkg::POS_W-1:0] position;
    logic                      overflow;
  } search_result_t;

  logic [rss_pkg::BYTE_W-1:0] pat_bytes [MAX_PATTERN];
  logic [rss_pkg::BYTE_W-1:0] window [MAX_PATTERN];  // index 0 holds the newest text byte
  int unsigned       pat_len;
  int unsigned       text_len;
  int unsigned       hit_start;
  bit                pat_open;
  bit                hit;
  bit                ovf;
  int                fail_count = 0;
  search_result_t    awaited[$];

  assign errors = fail_count;

  task automatic clear_text();
    foreach (window[i]) window[i] = '0;
    text_len  = 0;
    hit       = 0;
    hit_start = 0;
    ovf       = 0;
  endtask

  function automatic bit window_hit();
    if (pat_len == 0 || text_len < pat_len) return 0;
    for (int unsigned m = 0; m < pat_len; m++) begin
      if (window[pat_len - 1 - m] != pat_bytes[m]) return 0;
    end
    return 1;
  endfunction

  task automatic absorb_item(input rss_pkg::op_t op, input logic [rss_pkg::BYTE_W-1:0] data,
                             input logic lst);
    search_result_t res;
    case (op)
      rss_pkg::OP_PAT_MARK, rss_pkg::OP_PAT_BYTE: begin
        // first pattern item after a closed pattern drops any text in progress
        if (!pat_open) begin
          pat_open = 1;
          pat_len  = 0;
          clear_text();
        end
        if (op == rss_pkg::OP_PAT_BYTE) begin
          if (pat_len < MAX_PATTERN) begin
            pat_bytes[pat_len] = data;
            pat_len++;
          end else begin
            ovf = 1;
          end
        end
        if (lst) pat_open = 0;
      end
      default: begin
        pat_open = 0;
        if (op == rss_pkg::OP_TEXT_BYTE) begin
          if (text_len < MAX_TEXT) begin
            for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = data;
            text_len++;
            if (window_hit()) begin
              hit       = 1;
              hit_start = text_len - pat_len;
            end
          end else begin
            ovf = 1;
          end
        end
        if (lst) begin
          res.found    = hit;
          res.position = hit ? hit_start[rss_pkg::POS_W-1:0] : '0;
          res.overflow = ovf;
          awaited.push_back(res);
          clear_text();
        end
      end
    endcase
  endtask

  task automatic check_result(input search_result_t got);
    search_result_t want;
    if (awaited.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected result: found=%0d position=%0d overflow=%0d",
                 got.found, got.position, got.overflow);
      fail_count++;
    end else begin
      want = awaited.pop_front();
      if (got.found != want.found || got.position != want.position ||
          got.overflow != want.overflow) begin
        if (fail_count < 10)
          $display("mismatch: expected found=%0d pos=%0d ovf=%0d, got found=%0d pos=%0d ovf=%0d",
                   want.found, want.position, want.overflow,
                   got.found, got.position, got.overflow);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (pat_bytes[i]) pat_bytes[i] = '0;
      pat_len  = 0;
      pat_open = 0;
      clear_text();
      awaited.delete();
    end else begin
      // retire before predicting: a result seen now belongs to an earlier item
      if (result.valid && result.ready)
        check_result({result.found, result.position, result.overflow});
      if (request.valid && request.ready)
        absorb_item(rss_pkg::op_t'({request.command, request.byte_valid}),
                    request.data_byte, request.last);
    end
    pending <= awaited.size();
  end

endmodule

// File: tb/tb_rightmost_substring_search.sv
`timescale 1ns / 1ps
// Top of the substring search testbench: clock, reset, item traffic and verdict.
module tb_rightmost_substring_search;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  // how a pattern or text is closed
  localparam int END_ON_BYTE = 0;
  localparam int END_ON_MARK = 1;
  localparam int END_NONE    = 2;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   sent = 0;
  int   src_idle_pct = 23;
  int   snk_idle_pct = 52;

  rss_in_if  request();
  rss_out_if result();

  rightmost_substring_search u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result)
  );

  rss_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [7:0] data, input logic bv,
                           input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      request.valid <= 1'b0;
      @(posedge clk);
    end
    request.valid      <= 1'b1;
    request.command    <= cmd;
    request.data_byte  <= data;
    request.byte_valid <= bv;
    request.last       <= lst;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    sent++;
  endtask

  // hold off until every predicted result has come back
  task automatic drain();
    request.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_pattern(input byte_q_t pat, input int ending);
    if (pat.size() == 0 && ending == END_NONE)
      send_item(CMD_PATTERN, 8'($urandom), 1'b0, 1'b0);
    foreach (pat[i]) begin
      if ($urandom_range(19) == 0) send_item(CMD_PATTERN, 8'($urandom), 1'b0, 1'b0);
      send_item(CMD_PATTERN, pat[i], 1'b1, ending == END_ON_BYTE && i == pat.size() - 1);
    end
    if (ending == END_ON_MARK || (ending == END_ON_BYTE && pat.size() == 0))
      send_item(CMD_PATTERN, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_text(input byte_q_t txt, input int ending);
    foreach (txt[i]) begin
      if ($urandom_range(19) == 0) send_item(CMD_TEXT, 8'($urandom), 1'b0, 1'b0);
      send_item(CMD_TEXT, txt[i], 1'b1, ending == END_ON_BYTE && i == txt.size() - 1);
    end
    if (ending == END_ON_MARK || (ending == END_ON_BYTE && txt.size() == 0))
      send_item(CMD_TEXT, 8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] base, input int span);
    if ($urandom_range(9) == 0) return 8'($urandom);
    return base + 8'($urandom_range(span - 1));
  endfunction

  function automatic int pick_ending();
    int r;
    r = $urandom_range(99);
    if (r < 78) return END_ON_BYTE;
    if (r < 92) return END_ON_MARK;
    return END_NONE;
  endfunction

  // one pattern followed by a few texts; the first sessions are pinned to the bounds
  task automatic random_session(input int idx);
    byte_q_t     pat;
    byte_q_t     txt;
    logic [7:0]  base;
    int          span;
    int          plen;
    int          tlen;
    int          r;
    int          at;

    base = 8'($urandom);
    span = $urandom_range(1, 3);
    r    = $urandom_range(99);
    if (idx == 0)     plen = 1;
    else if (idx == 1) plen = 18;
    else if (r < 8)   plen = 0;
    else if (r < 70)  plen = $urandom_range(1, 4);
    else if (r < 85)  plen = $urandom_range(5, 15);
    else if (r < 93)  plen = 16;
    else              plen = $urandom_range(17, 20);
    for (int i = 0; i < plen; i++) pat.push_back(pick_byte(base, span));
    send_pattern(pat, (idx < 2) ? END_ON_BYTE : pick_ending());

    if (idx == 0) begin
      // full-length run of the one pattern byte: rightmost start lands on 127
      for (int i = 0; i < 131; i++) txt.push_back(pat[0]);
      send_text(txt, END_ON_BYTE);
      return;
    end

    for (int t = $urandom_range(1, 4); t > 0; t--) begin
      txt.delete();
      tlen = ($urandom_range(99) < 3) ? $urandom_range(126, 134) : $urandom_range(0, 16);
      for (int i = 0; i < tlen; i++) txt.push_back(pick_byte(base, span));
      if (plen > 0 && plen <= tlen && $urandom_range(99) < 40) begin
        at = $urandom_range(tlen - plen);
        for (int i = 0; i < plen; i++) txt[at + i] = pat[i];
      end
      send_text(txt, pick_ending());
    end
  endtask

  initial begin
    int phase;
    int next_phase;

    rst                <= 1'b1;
    request.valid      <= 1'b0;
    request.command    <= CMD_PATTERN;
    request.data_byte  <= '0;
    request.byte_valid <= 1'b0;
    request.last       <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_TEXT, 8'h5A, 1'b0, 1'b1);       // text end with no pattern yet
    send_item(CMD_PATTERN, 8'h00, 1'b1, 1'b0);
    send_item(CMD_PATTERN, 8'hFF, 1'b1, 1'b1);
    send_item(CMD_TEXT, 8'h00, 1'b1, 1'b0);
    send_item(CMD_TEXT, 8'hFF, 1'b1, 1'b0);
    send_item(CMD_TEXT, 8'h00, 1'b1, 1'b0);
    send_item(CMD_TEXT, 8'hFF, 1'b1, 1'b1);       // two hits, rightmost at 2
    send_item(CMD_TEXT, 8'hFF, 1'b1, 1'b0);
    send_item(CMD_TEXT, 8'h00, 1'b1, 1'b1);
    send_item(CMD_PATTERN, 8'hC3, 1'b0, 1'b1);    // empty pattern
    send_item(CMD_TEXT, 8'hAA, 1'b1, 1'b1);
    send_item(CMD_PATTERN, 8'h11, 1'b0, 1'b0);    // mark only opens a pattern
    send_item(CMD_PATTERN, 8'h41, 1'b1, 1'b0);
    send_item(CMD_TEXT, 8'h41, 1'b1, 1'b0);       // text closes the open pattern
    send_item(CMD_TEXT, 8'h99, 1'b0, 1'b0);
    send_item(CMD_TEXT, 8'h41, 1'b1, 1'b0);
    send_item(CMD_TEXT, 8'h77, 1'b0, 1'b1);
    send_item(CMD_TEXT, 8'h41, 1'b1, 1'b0);       // dropped by the next pattern
    send_item(CMD_PATTERN, 8'h80, 1'b1, 1'b1);
    send_item(CMD_TEXT, 8'h41, 1'b1, 1'b0);
    send_item(CMD_TEXT, 8'h80, 1'b1, 1'b1);
    drain();

    phase = 0;
    for (int s = 0; sent < 450; s++) begin
      next_phase = (sent < 170) ? 0 : (sent < 330) ? 1 : 2;
      if (next_phase != phase) begin
        drain();
        phase = next_phase;
        src_idle_pct = (phase == 1) ? 52 : 0;
        snk_idle_pct = (phase == 1) ? 23 : 0;
      end
      random_session(s);
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
